// ===== rtl/cpr_pkg.sv =====
// Package for the clock page replacement block.
// Holds sizes, opcodes, flag bit positions, state type and memory write structs.
// No dependencies.
`default_nettype none
package cpr_pkg;
  localparam int unsigned NUM_PROCESSES     = 32;
  localparam int unsigned PAGES_PER_PROCESS = 32;
  localparam int unsigned NUM_FRAMES        = 256;
  localparam int unsigned PAGE_BYTES        = 1024;
  localparam int unsigned MAP_DEPTH         = NUM_PROCESSES * PAGES_PER_PROCESS;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned PROC_W  = 5;
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned PAGE_W  = 5;
  localparam int unsigned MAP_AW  = $clog2(MAP_DEPTH);
  localparam int unsigned MAP_W   = FRAME_W + 1;
  localparam int unsigned FLAG_W  = 3;
  localparam int unsigned OWN_W   = PROC_W + PAGE_W;
  localparam int unsigned PAGE_SH = $clog2(PAGE_BYTES);
  localparam int unsigned CNT_W   = MAP_AW + 1;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_FAULT  = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam int unsigned FLG_OCC = 0;
  localparam int unsigned FLG_REF = 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LK, S_RM_RD, S_RM_WR, S_FLT, S_EV_RD, S_EV_CK, S_MAP_WR, S_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] addr;
    logic [MAP_W-1:0]  data;
  } map_wr_t;

  typedef struct packed {
    logic               we;
    logic [FRAME_W-1:0] addr;
    logic [FLAG_W-1:0]  data;
  } flg_wr_t;

  typedef struct packed {
    logic               we;
    logic [FRAME_W-1:0] addr;
    logic [OWN_W-1:0]   data;
  } own_wr_t;
endpackage
`default_nettype wire

// ===== rtl/cpr_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module cpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/cpr_core.sv =====
// Sequencer for lookup, fault walk and remove over the page map, flag and owner RAMs.
// Depends on cpr_pkg; holds the clock hand and the result register.
`default_nettype none
module cpr_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [cpr_pkg::OP_W-1:0]        opcode_i,
  input  wire logic [cpr_pkg::PROC_W-1:0]      process_index_i,
  input  wire logic [cpr_pkg::ADDR_W-1:0]      address_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [cpr_pkg::FRAME_W-1:0]          frame_o,
  output logic                                 mapped_o,
  output logic                                 evicted_o,
  output logic [cpr_pkg::PROC_W-1:0]           victim_process_o,
  output logic [cpr_pkg::PAGE_W-1:0]           victim_page_o,
  output cpr_pkg::map_wr_t                     map_wr_o,
  output logic [cpr_pkg::MAP_AW-1:0]           map_raddr_o,
  input  wire logic [cpr_pkg::MAP_W-1:0]       map_rdata_i,
  output cpr_pkg::flg_wr_t                     flg_wr_o,
  output logic [cpr_pkg::FRAME_W-1:0]          flg_raddr_o,
  input  wire logic [cpr_pkg::FLAG_W-1:0]      flg_rdata_i,
  output cpr_pkg::own_wr_t                     own_wr_o,
  output logic [cpr_pkg::FRAME_W-1:0]          own_raddr_o,
  input  wire logic [cpr_pkg::OWN_W-1:0]       own_rdata_i
);
  import cpr_pkg::*;

  state_e             state_q, state_d;
  logic [PROC_W-1:0]  proc_q, proc_d;
  logic [PAGE_W-1:0]  page_q, page_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [FRAME_W-1:0] hand_q, hand_d;
  logic [FRAME_W-1:0] rd_f_q, rd_f_d;
  logic [FRAME_W-1:0] ev_f_q, ev_f_d;
  logic               pv_q, pv_d;
  logic [FRAME_W-1:0] tk_frame_q, tk_frame_d;
  logic               tk_map_q, tk_map_d;
  logic               tk_ev_q, tk_ev_d;
  logic [OWN_W-1:0]   vic_q, vic_d;
  logic               ov_q, ov_d;
  logic [FRAME_W-1:0] r_frame_q, r_frame_d;
  logic               r_map_q, r_map_d;
  logic               r_ev_q, r_ev_d;
  logic [OWN_W-1:0]   r_vic_q, r_vic_d;

  logic [PAGE_W-1:0]  in_page;
  logic [MAP_AW-1:0]  in_idx, cur_idx, rm_idx, vic_idx;
  logic               issue, take;

  assign in_page = address_i[PAGE_SH +: PAGE_W];
  assign in_idx  = MAP_AW'(process_index_i) * MAP_AW'(PAGES_PER_PROCESS) + MAP_AW'(in_page);
  assign cur_idx = MAP_AW'(proc_q) * MAP_AW'(PAGES_PER_PROCESS) + MAP_AW'(page_q);
  assign rm_idx  = MAP_AW'(proc_q) * MAP_AW'(PAGES_PER_PROCESS) + MAP_AW'(cnt_q);
  assign vic_idx = MAP_AW'(vic_q[PAGE_W +: PROC_W]) * MAP_AW'(PAGES_PER_PROCESS)
                 + MAP_AW'(vic_q[PAGE_W-1:0]);

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = ov_q;
  assign frame_o          = r_frame_q;
  assign mapped_o         = r_map_q;
  assign evicted_o        = r_ev_q;
  assign victim_process_o = r_vic_q[PAGE_W +: PROC_W];
  assign victim_page_o    = r_vic_q[PAGE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      hand_q  <= '0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hand_q  <= hand_d;
      pv_q    <= pv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_q     <= proc_d;
    page_q     <= page_d;
    rd_f_q     <= rd_f_d;
    ev_f_q     <= ev_f_d;
    tk_frame_q <= tk_frame_d;
    tk_map_q   <= tk_map_d;
    tk_ev_q    <= tk_ev_d;
    vic_q      <= vic_d;
    r_frame_q  <= r_frame_d;
    r_map_q    <= r_map_d;
    r_ev_q     <= r_ev_d;
    r_vic_q    <= r_vic_d;
  end

  always_comb begin
    state_d    = state_q;
    proc_d     = proc_q;
    page_d     = page_q;
    cnt_d      = cnt_q;
    hand_d     = hand_q;
    rd_f_d     = rd_f_q;
    ev_f_d     = ev_f_q;
    pv_d       = 1'b0;
    tk_frame_d = tk_frame_q;
    tk_map_d   = tk_map_q;
    tk_ev_d    = tk_ev_q;
    vic_d      = vic_q;
    ov_d       = ov_q & out_stall_i;
    r_frame_d  = r_frame_q;
    r_map_d    = r_map_q;
    r_ev_d     = r_ev_q;
    r_vic_d    = r_vic_q;
    map_wr_o   = '0;
    flg_wr_o   = '0;
    own_wr_o   = '0;
    map_raddr_o = cur_idx;
    flg_raddr_o = rd_f_q;
    own_raddr_o = rd_f_q;
    issue      = 1'b0;
    take       = 1'b0;

    case (state_q)
      S_CLR: begin
        map_wr_o = '{we: 1'b1, addr: cnt_q[MAP_AW-1:0], data: '0};
        flg_wr_o = '{we: 1'b1, addr: cnt_q[FRAME_W-1:0], data: '0};
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        map_raddr_o = in_idx;
        if (in_valid_i) begin
          proc_d     = process_index_i;
          page_d     = in_page;
          tk_frame_d = '0;
          tk_map_d   = 1'b0;
          tk_ev_d    = 1'b0;
          vic_d      = '0;
          cnt_d      = '0;
          rd_f_d     = hand_q;
          case (opcode_i)
            OP_LOOKUP: state_d = S_LK;
            OP_FAULT:  state_d = S_FLT;
            OP_REMOVE: state_d = S_RM_RD;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_LK: begin
        if (map_rdata_i[FRAME_W]) begin
          tk_frame_d = map_rdata_i[FRAME_W-1:0];
          tk_map_d   = 1'b1;
        end
        state_d = S_DONE;
      end
      S_RM_RD: begin
        map_raddr_o = rm_idx;
        state_d     = S_RM_WR;
      end
      S_RM_WR: begin
        if (map_rdata_i[FRAME_W]) begin
          map_wr_o = '{we: 1'b1, addr: rm_idx, data: '0};
          flg_wr_o = '{we: 1'b1, addr: map_rdata_i[FRAME_W-1:0], data: '0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PAGES_PER_PROCESS - 1)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RM_RD;
        end
      end
      S_FLT: begin
        if (pv_q) begin
          hand_d = ev_f_q;
          if (!flg_rdata_i[FLG_OCC]) begin
            take     = 1'b1;
            flg_wr_o = '{we: 1'b1, addr: ev_f_q,
                         data: flg_rdata_i | FLAG_W'(1 << FLG_OCC)};
            own_wr_o = '{we: 1'b1, addr: ev_f_q, data: {proc_q, page_q}};
            tk_frame_d = ev_f_q;
            tk_map_d   = 1'b1;
            state_d    = S_MAP_WR;
          end else if (!flg_rdata_i[FLG_REF]) begin
            flg_wr_o = '{we: 1'b1, addr: ev_f_q,
                         data: flg_rdata_i | FLAG_W'(1 << FLG_REF)};
          end else begin
            take     = 1'b1;
            flg_wr_o = '{we: 1'b1, addr: ev_f_q, data: FLAG_W'(1 << FLG_OCC)};
            own_wr_o = '{we: 1'b1, addr: ev_f_q, data: {proc_q, page_q}};
            vic_d      = own_rdata_i;
            tk_frame_d = ev_f_q;
            tk_map_d   = 1'b1;
            tk_ev_d    = 1'b1;
            state_d    = S_EV_RD;
          end
        end
        issue = !take && (cnt_q != CNT_W'(NUM_FRAMES));
        if (issue) begin
          rd_f_d = rd_f_q + 1'b1;
          ev_f_d = rd_f_q;
          cnt_d  = cnt_q + 1'b1;
          pv_d   = 1'b1;
        end else if (!take && pv_q) begin
          state_d = S_DONE;
        end
      end
      S_EV_RD: begin
        map_raddr_o = vic_idx;
        state_d     = S_EV_CK;
      end
      S_EV_CK: begin
        if (map_rdata_i[FRAME_W] && map_rdata_i[FRAME_W-1:0] == tk_frame_q) begin
          map_wr_o = '{we: 1'b1, addr: vic_idx, data: '0};
        end
        state_d = S_MAP_WR;
      end
      S_MAP_WR: begin
        map_wr_o = '{we: 1'b1, addr: cur_idx, data: {1'b1, tk_frame_q}};
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d      = 1'b1;
          r_frame_d = tk_frame_q;
          r_map_d   = tk_map_q;
          r_ev_d    = tk_ev_q;
          r_vic_d   = vic_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/clock_page_replacement_top.sv =====
// Top level of the clock page replacement block.
// Depends on cpr_pkg, cpr_ram and cpr_core.
//
// Input channel: in_valid_i / in_stall_o carry one word of opcode_i,
// process_index_i and address_i. Output channel: out_valid_o / out_stall_i
// carry one word of frame_o, mapped_o, evicted_o, victim_process_o and
// victim_page_o. A word moves at a clock edge with valid high and stall low.
// Every input word yields exactly one output word.
// A lookup reads the page map. A remove reads all 32 map entries of the process,
// clearing mapped ones. A fault walks the flag RAM (one flag RAM read per cycle,
// pipelined), then updates the map. Each ends by loading the output register. One
// word is in work at a time; the next is taken once the result is loaded. After
// reset a clearing pass zeroes the page map and flags; in_stall_o stays high
// during it. If the receiver stalls, the result holds in the output register and
// a finished next result waits until it drains.
`default_nettype none
module clock_page_replacement_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [cpr_pkg::OP_W-1:0]    opcode_i,
  input  wire logic [cpr_pkg::PROC_W-1:0]  process_index_i,
  input  wire logic [cpr_pkg::ADDR_W-1:0]  address_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [cpr_pkg::FRAME_W-1:0]      frame_o,
  output logic                             mapped_o,
  output logic                             evicted_o,
  output logic [cpr_pkg::PROC_W-1:0]       victim_process_o,
  output logic [cpr_pkg::PAGE_W-1:0]       victim_page_o
);
  import cpr_pkg::*;

  map_wr_t            map_wr;
  flg_wr_t            flg_wr;
  own_wr_t            own_wr;
  logic [MAP_AW-1:0]  map_raddr;
  logic [MAP_W-1:0]   map_rdata;
  logic [FRAME_W-1:0] flg_raddr, own_raddr;
  logic [FLAG_W-1:0]  flg_rdata;
  logic [OWN_W-1:0]   own_rdata;

  cpr_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk_i, .we_i(map_wr.we), .waddr_i(map_wr.addr), .wdata_i(map_wr.data),
    .raddr_i(map_raddr), .rdata_o(map_rdata)
  );

  cpr_ram #(.WIDTH(FLAG_W), .DEPTH(NUM_FRAMES)) u_flags (
    .clk_i, .we_i(flg_wr.we), .waddr_i(flg_wr.addr), .wdata_i(flg_wr.data),
    .raddr_i(flg_raddr), .rdata_o(flg_rdata)
  );

  cpr_ram #(.WIDTH(OWN_W), .DEPTH(NUM_FRAMES)) u_owner (
    .clk_i, .we_i(own_wr.we), .waddr_i(own_wr.addr), .wdata_i(own_wr.data),
    .raddr_i(own_raddr), .rdata_o(own_rdata)
  );

  cpr_core u_core (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .process_index_i,
    .address_i, .out_valid_o, .out_stall_i, .frame_o, .mapped_o, .evicted_o,
    .victim_process_o, .victim_page_o,
    .map_wr_o(map_wr), .map_raddr_o(map_raddr), .map_rdata_i(map_rdata),
    .flg_wr_o(flg_wr), .flg_raddr_o(flg_raddr), .flg_rdata_i(flg_rdata),
    .own_wr_o(own_wr), .own_raddr_o(own_raddr), .own_rdata_i(own_rdata)
  );
endmodule
`default_nettype wire
